FILE: design/lpw_pkg.sv
// Shared types and constants for the line pixel walker.
package lpw_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned DiffW   = CoordW + 1;            // signed endpoint difference
  localparam int unsigned DecW    = CoordW + 3;            // signed decision variable
  localparam int unsigned NumW    = ColorW + CoordW;       // color times length
  localparam int unsigned RemW    = NumW + 2;              // 2*num + L
  localparam int unsigned DeltaW  = ColorW + 1;            // signed color difference
  localparam int unsigned NumChan = 3;
  localparam int unsigned DivCntW = $clog2(ColorW);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [ColorW-1:0] color_t;

  // Octant cases after ordering by x
  typedef enum logic [1:0] {
    OCT_RISE_SHALLOW = 2'd0,
    OCT_RISE_STEEP   = 2'd1,
    OCT_FALL_SHALLOW = 2'd2,
    OCT_FALL_STEEP   = 2'd3
  } octant_e;

  // Input mode codes
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch a new segment
    logic step;       // advance one pixel
    logic mult;       // form start color times length
    logic div_init;   // seed the rounding dividers
    logic div_iter;   // one quotient bit
    logic out_load;   // move result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic active;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

FILE: design/lpw_ctrl.sv
// Control state machine for the line pixel walker.
module lpw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            mode_i,
  input  lpw_pkg::status_t status_i,
  output logic            in_ready_o,
  output lpw_pkg::cmd_t   cmd_o
);
  import lpw_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_LOAD) begin
            state_d = ST_MULT;
          end else if (status_i.active) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_MULT: state_d = ST_IDLE;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = accept && (mode_i == MODE_LOAD);
        cmd_o.step  = accept && (mode_i == MODE_STEP) && status_i.active;
      end
      ST_MULT: cmd_o.mult     = 1'b1;
      ST_PREP: cmd_o.div_init = 1'b1;
      ST_DIV:  cmd_o.div_iter = 1'b1;
      ST_HOLD: cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: design/lpw_datapath.sv
// Segment setup, Bresenham stepping, color rounding dividers and output register.
module lpw_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpw_pkg::cmd_t    cmd_i,
  output lpw_pkg::status_t status_o,
  input  lpw_pkg::coord_t  x_start_i,
  input  lpw_pkg::coord_t  y_start_i,
  input  lpw_pkg::coord_t  x_end_i,
  input  lpw_pkg::coord_t  y_end_i,
  input  lpw_pkg::color_t  r_start_i,
  input  lpw_pkg::color_t  g_start_i,
  input  lpw_pkg::color_t  b_start_i,
  input  lpw_pkg::color_t  r_end_i,
  input  lpw_pkg::color_t  g_end_i,
  input  lpw_pkg::color_t  b_end_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output lpw_pkg::coord_t  pixel_x_o,
  output lpw_pkg::coord_t  pixel_y_o,
  output lpw_pkg::color_t  red_o,
  output lpw_pkg::color_t  green_o,
  output lpw_pkg::color_t  blue_o,
  output logic             last_pixel_o
);
  import lpw_pkg::*;

  // Segment state
  coord_t                   col_q, row_q;
  logic signed [DecW-1:0]   dec_q;
  octant_e                  oct_q;
  logic signed [DiffW-1:0]  a_q, b_q;
  coord_t                   len_q, steps_q;
  logic                     active_q, last_q;
  color_t                   c0_q    [NumChan];
  logic signed [DeltaW-1:0] delta_q [NumChan];
  logic [NumW-1:0]          num_q   [NumChan];

  // Divider state
  logic [RemW-1:0]          rem_q   [NumChan];
  color_t                   quo_q   [NumChan];
  logic [NumW-1:0]          dsr_q;
  logic [DivCntW-1:0]       cnt_q;

  // Output register
  logic                     out_valid_q;
  coord_t                   px_q, py_q;
  color_t                   oc_q    [NumChan];
  logic                     olast_q;

  // ---------------- load setup ----------------
  logic                     swap;
  coord_t                   x0, y0, x1, y1;
  color_t                   cs [NumChan];
  color_t                   ce [NumChan];
  color_t                   in_s [NumChan];
  color_t                   in_e [NumChan];
  coord_t                   dx, dy;
  logic                     rising, shallow;
  logic signed [DiffW-1:0]  a_new, b_new;
  logic signed [DecW-1:0]   a_ext, b_ext, dec_new;
  octant_e                  oct_new;
  coord_t                   len_new;

  assign in_s[0] = r_start_i;
  assign in_s[1] = g_start_i;
  assign in_s[2] = b_start_i;
  assign in_e[0] = r_end_i;
  assign in_e[1] = g_end_i;
  assign in_e[2] = b_end_i;

  always_comb begin
    swap = x_end_i < x_start_i;
    x0   = swap ? x_end_i   : x_start_i;
    y0   = swap ? y_end_i   : y_start_i;
    x1   = swap ? x_start_i : x_end_i;
    y1   = swap ? y_start_i : y_end_i;
    for (int i = 0; i < NumChan; i++) begin
      cs[i] = swap ? in_e[i] : in_s[i];
      ce[i] = swap ? in_s[i] : in_e[i];
    end
    a_new   = $signed({1'b0, y0}) - $signed({1'b0, y1});
    b_new   = $signed({1'b0, x1}) - $signed({1'b0, x0});
    a_ext   = DecW'(a_new);
    b_ext   = DecW'(b_new);
    dx      = x1 - x0;
    rising  = y0 < y1;
    dy      = rising ? (y1 - y0) : (y0 - y1);
    shallow = (dx != '0) && (dy <= dx);
    len_new = shallow ? dx : dy;
    unique case ({rising, shallow})
      2'b11: begin oct_new = OCT_RISE_SHALLOW; dec_new = (a_ext <<< 1) + b_ext; end
      2'b10: begin oct_new = OCT_RISE_STEEP;   dec_new = a_ext + (b_ext <<< 1); end
      2'b01: begin oct_new = OCT_FALL_SHALLOW; dec_new = (a_ext <<< 1) - b_ext; end
      default: begin oct_new = OCT_FALL_STEEP; dec_new = a_ext - (b_ext <<< 1); end
    endcase
  end

  // ---------------- Bresenham step ----------------
  logic signed [DecW-1:0] sa, sb, dec_step;
  logic                   dpos, mv_col, mv_row;

  always_comb begin
    sa     = DecW'(a_q);
    sb     = DecW'(b_q);
    dpos   = dec_q > 0;
    mv_col = 1'b1;
    mv_row = 1'b1;
    unique case (oct_q)
      OCT_RISE_SHALLOW: begin
        mv_row   = !dpos;
        dec_step = dpos ? (sa <<< 1) : ((sa + sb) <<< 1);
      end
      OCT_RISE_STEEP: begin
        mv_col   = dpos;
        dec_step = dpos ? ((sa + sb) <<< 1) : (sb <<< 1);
      end
      OCT_FALL_SHALLOW: begin
        mv_row   = dpos;
        dec_step = dpos ? ((sa - sb) <<< 1) : (sa <<< 1);
      end
      default: begin
        mv_col   = !dpos;
        dec_step = dpos ? -(sb <<< 1) : ((sa - sb) <<< 1);
      end
    endcase
  end

  logic             step_last;
  logic [CoordW:0]  steps_inc;
  assign steps_inc = {1'b0, steps_q} + (CoordW+1)'(1);
  assign step_last = steps_inc >= {1'b0, len_q};

  // Segment registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (cmd_i.load) begin
      active_q <= len_new != '0;
    end else if (cmd_i.step && step_last) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q   <= x0;
      row_q   <= y0;
      dec_q   <= dec_new;
      oct_q   <= oct_new;
      a_q     <= a_new;
      b_q     <= b_new;
      len_q   <= len_new;
      steps_q <= '0;
      for (int i = 0; i < NumChan; i++) begin
        c0_q[i]    <= cs[i];
        delta_q[i] <= $signed({1'b0, ce[i]}) - $signed({1'b0, cs[i]});
      end
    end else if (cmd_i.step) begin
      col_q   <= mv_col ? col_q + coord_t'(1) : col_q;
      if (oct_q == OCT_RISE_SHALLOW || oct_q == OCT_RISE_STEEP) begin
        row_q <= mv_row ? row_q + coord_t'(1) : row_q;
      end else begin
        row_q <= mv_row ? row_q - coord_t'(1) : row_q;
      end
      dec_q   <= dec_q + dec_step;
      steps_q <= steps_inc[CoordW-1:0];
      last_q  <= step_last;
      // numerator tracks c0*(L-s) + c1*s
      for (int i = 0; i < NumChan; i++) begin
        num_q[i] <= num_q[i] + NumW'(delta_q[i]);
      end
    end else if (cmd_i.mult) begin
      for (int i = 0; i < NumChan; i++) begin
        num_q[i] <= NumW'(c0_q[i]) * NumW'(len_q);
      end
    end
  end

  // ---------------- rounding dividers: (2*num + L) / (2*L), one bit a cycle ------------
  logic [RemW-1:0] dsr_ext;
  assign dsr_ext = RemW'(dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= DivCntW'(ColorW - 1);
    end else if (cmd_i.div_iter) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dsr_q <= {len_q, {(NumW-CoordW){1'b0}}};
      for (int i = 0; i < NumChan; i++) begin
        rem_q[i] <= {1'b0, num_q[i], 1'b0} + RemW'(len_q);
        quo_q[i] <= '0;
      end
    end else if (cmd_i.div_iter) begin
      dsr_q <= dsr_q >> 1;
      for (int i = 0; i < NumChan; i++) begin
        if (rem_q[i] >= dsr_ext) begin
          rem_q[i] <= rem_q[i] - dsr_ext;
          quo_q[i] <= {quo_q[i][ColorW-2:0], 1'b1};
        end else begin
          quo_q[i] <= {quo_q[i][ColorW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      px_q    <= col_q;
      py_q    <= row_q;
      olast_q <= last_q;
      for (int i = 0; i < NumChan; i++) begin
        oc_q[i] <= quo_q[i];
      end
    end
  end

  assign status_o.active   = active_q;
  assign status_o.div_last = cnt_q == '0;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign red_o        = oc_q[0];
  assign green_o      = oc_q[1];
  assign blue_o       = oc_q[2];
  assign last_pixel_o = olast_q;

endmodule

FILE: design/line_pixel_walker_color_interp.sv
// Line pixel walker: Bresenham line stepping with per-pixel rounded RGB interpolation.
// A load transaction (mode 0) yields no pixel; a step transaction (mode 1) on an
// active segment yields one pixel after a position update, a divider seed state, the three
// restoring dividers that round each color channel one quotient bit per cycle (8 bits),
// and an output transfer. A step with no active segment is consumed without a pixel.
// The input accepts the next transaction while a finished pixel still waits in the
// output register; a pixel that finishes while the previous one is still waiting holds
// until the register frees up. The final pixel of a segment carries last_pixel_o; the
// start pixel is never emitted.
module line_pixel_walker_color_interp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  input  lpw_pkg::coord_t x_start_i,
  input  lpw_pkg::coord_t y_start_i,
  input  lpw_pkg::coord_t x_end_i,
  input  lpw_pkg::coord_t y_end_i,
  input  lpw_pkg::color_t r_start_i,
  input  lpw_pkg::color_t g_start_i,
  input  lpw_pkg::color_t b_start_i,
  input  lpw_pkg::color_t r_end_i,
  input  lpw_pkg::color_t g_end_i,
  input  lpw_pkg::color_t b_end_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpw_pkg::coord_t pixel_x_o,
  output lpw_pkg::coord_t pixel_y_o,
  output lpw_pkg::color_t red_o,
  output lpw_pkg::color_t green_o,
  output lpw_pkg::color_t blue_o,
  output logic            last_pixel_o
);
  import lpw_pkg::*;

  cmd_t    cmd;
  status_t status;

  lpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lpw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .r_start_i    (r_start_i),
    .g_start_i    (g_start_i),
    .b_start_i    (b_start_i),
    .r_end_i      (r_end_i),
    .g_end_i      (g_end_i),
    .b_end_i      (b_end_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

FILE: dv/line_pixel_walker_color_interp_tb.sv
// Self-checking testbench for the line pixel walker with color interpolation.
module line_pixel_walker_color_interp_tb;
  import lpw_pkg::*;

  localparam int NumDirected  = 23;
  localparam int RandomItems  = 550;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 40;

  // One input transaction, field for field as on the ports
  typedef struct packed {
    mode_e  mode;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    color_t rs;
    color_t gs;
    color_t bs;
    color_t re;
    color_t ge;
    color_t be;
  } walk_req_t;

  // One emitted pixel
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t r;
    color_t g;
    color_t b;
    logic   last;
  } pix_t;

  // Directed row: typed = 1 means the pixel below is the expected one
  typedef struct packed {
    walk_req_t req;
    logic      typed;
    pix_t      pix;
  } dir_row_t;

  localparam pix_t NO_PIX = '0;
  localparam walk_req_t STEP_REQ = '{MODE_STEP, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_ready_o;
  logic   mode_i       = 1'b0;
  coord_t x_start_i    = '0;
  coord_t y_start_i    = '0;
  coord_t x_end_i      = '0;
  coord_t y_end_i      = '0;
  color_t r_start_i    = '0;
  color_t g_start_i    = '0;
  color_t b_start_i    = '0;
  color_t r_end_i      = '0;
  color_t g_end_i      = '0;
  color_t b_end_i      = '0;
  logic   out_valid_o;
  logic   out_ready_i  = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  color_t red_o;
  color_t green_o;
  color_t blue_o;
  logic   last_pixel_o;

  line_pixel_walker_color_interp DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .r_start_i    (r_start_i),
    .g_start_i    (g_start_i),
    .b_start_i    (b_start_i),
    .r_end_i      (r_end_i),
    .g_end_i      (g_end_i),
    .b_end_i      (b_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_pixel_o (last_pixel_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Line walker state as the predictor sees it
  coord_t  pen_x;
  coord_t  pen_y;
  int      pen_dec;
  octant_e pen_oct;
  int      pen_done;
  int      pen_len;
  int      seg_x0, seg_y0, seg_x1, seg_y1;
  color_t  col_from [3];
  color_t  col_to   [3];
  bit      pen_on;

  pix_t pix_expected [$];
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   rx_hold     = 0;
  bit   tx_calm     = 1'b0;
  bit   rx_calm     = 1'b0;

  // Rounded linear blend along the major axis
  function automatic color_t shade(color_t c0, color_t c1, int s, int len);
    int unsigned num;
    num = c0 * (len - s) + c1 * s;
    return color_t'((2 * num + len) / (2 * len));
  endfunction

  // Order endpoints by x, classify the octant and seed the decision variable
  function automatic void seg_load(walk_req_t q);
    int     x0, y0, x1, y1, a, b, dy, t;
    color_t s [3];
    color_t e [3];
    color_t u;
    x0 = q.xs; y0 = q.ys; x1 = q.xe; y1 = q.ye;
    s[0] = q.rs; s[1] = q.gs; s[2] = q.bs;
    e[0] = q.re; e[1] = q.ge; e[2] = q.be;
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
      for (int i = 0; i < 3; i++) begin
        u = s[i]; s[i] = e[i]; e[i] = u;
      end
    end
    seg_x0 = x0; seg_y0 = y0; seg_x1 = x1; seg_y1 = y1;
    col_from = s;
    col_to   = e;
    a = y0 - y1;
    b = x1 - x0;
    if (y0 < y1) begin
      dy = y1 - y0;
      if (b > 0 && dy <= b) begin
        pen_oct = OCT_RISE_SHALLOW; pen_dec = 2 * a + b; pen_len = b;
      end else begin
        pen_oct = OCT_RISE_STEEP;   pen_dec = a + 2 * b; pen_len = dy;
      end
    end else begin
      dy = y0 - y1;
      if (b > 0 && dy <= b) begin
        pen_oct = OCT_FALL_SHALLOW; pen_dec = 2 * a - b; pen_len = b;
      end else begin
        pen_oct = OCT_FALL_STEEP;   pen_dec = a - 2 * b; pen_len = dy;
      end
    end
    pen_x    = coord_t'(x0);
    pen_y    = coord_t'(y0);
    pen_done = 0;
    pen_on   = (pen_len != 0);
  endfunction

  // Advance one pixel; returns 1 when a pixel comes out
  function automatic bit walk_step(output pix_t p);
    int a, b;
    p = NO_PIX;
    if (!pen_on) return 1'b0;
    a = seg_y0 - seg_y1;
    b = seg_x1 - seg_x0;
    case (pen_oct)
      OCT_RISE_SHALLOW: begin
        if (pen_dec <= 0) begin
          pen_x++; pen_y++; pen_dec += 2 * (a + b);
        end else begin
          pen_x++; pen_dec += 2 * a;
        end
      end
      OCT_RISE_STEEP: begin
        if (pen_dec > 0) begin
          pen_x++; pen_y++; pen_dec += 2 * (a + b);
        end else begin
          pen_y++; pen_dec += 2 * b;
        end
      end
      OCT_FALL_SHALLOW: begin
        if (pen_dec > 0) begin
          pen_x++; pen_y--; pen_dec += 2 * a - 2 * b;
        end else begin
          pen_x++; pen_dec += 2 * a;
        end
      end
      default: begin
        if (pen_dec <= 0) begin
          pen_x++; pen_y--; pen_dec += 2 * (a - b);
        end else begin
          pen_y--; pen_dec += -2 * b;
        end
      end
    endcase
    pen_done++;
    p.x    = pen_x;
    p.y    = pen_y;
    p.r    = shade(col_from[0], col_to[0], pen_done, pen_len);
    p.g    = shade(col_from[1], col_to[1], pen_done, pen_len);
    p.b    = shade(col_from[2], col_to[2], pen_done, pen_len);
    p.last = (pen_done >= pen_len);
    if (p.last) pen_on = 1'b0;
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_pixel(input pix_t got);
    pix_t want;
    if (pix_expected.size() == 0) begin
      log_mismatch($sformatf("pixel (%0d,%0d) with nothing expected", got.x, got.y));
      return;
    end
    want = pix_expected.pop_front();
    if (got.x != want.x)
      log_mismatch($sformatf("pixel_x got %0d want %0d", got.x, want.x));
    if (got.y != want.y)
      log_mismatch($sformatf("pixel_y got %0d want %0d", got.y, want.y));
    if (got.r != want.r)
      log_mismatch($sformatf("red got %0d want %0d", got.r, want.r));
    if (got.g != want.g)
      log_mismatch($sformatf("green got %0d want %0d", got.g, want.g));
    if (got.b != want.b)
      log_mismatch($sformatf("blue got %0d want %0d", got.b, want.b));
    if (got.last != want.last)
      log_mismatch($sformatf("last_pixel got %0d want %0d", got.last, want.last));
  endtask

  // Drive one transaction, wait for acceptance, then update the predictor
  task automatic send(input walk_req_t q, output bit got, output pix_t p);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= q.mode;
    x_start_i  <= q.xs;
    y_start_i  <= q.ys;
    x_end_i    <= q.xe;
    y_end_i    <= q.ye;
    r_start_i  <= q.rs;
    g_start_i  <= q.gs;
    b_start_i  <= q.bs;
    r_end_i    <= q.re;
    g_end_i    <= q.ge;
    b_end_i    <= q.be;
    do @(posedge clk_i); while (!in_ready_o);
    got = 1'b0;
    p   = NO_PIX;
    if (q.mode == MODE_LOAD) seg_load(q);
    else got = walk_step(p);
  endtask

  function automatic color_t pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return color_t'($urandom);
    endcase
  endfunction

  // Endpoint near a base point, clamped to the screen
  function automatic coord_t nudge(coord_t base, int span);
    int v;
    v = $urandom_range(0, 1) ? base + $urandom_range(0, span) : base - $urandom_range(0, span);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  function automatic walk_req_t rand_req(mode_e m);
    walk_req_t q;
    q.mode = m;
    q.xs = coord_t'($urandom); q.ys = coord_t'($urandom);
    q.xe = coord_t'($urandom); q.ye = coord_t'($urandom);
    q.rs = pick_color(); q.gs = pick_color(); q.bs = pick_color();
    q.re = pick_color(); q.ge = pick_color(); q.be = pick_color();
    return q;
  endfunction

  // Output side: random back-pressure, check every accepted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_pixel('{pixel_x_o, pixel_y_o, red_o, green_o, blue_o, last_pixel_o});
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_ready_i <= (rx_hold == 0);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t  dir_tab [NumDirected];
    walk_req_t q;
    pix_t      p;
    bit        got;
    int        items_sent;
    int        kind;
    int        steps;
    coord_t    bx, by;

    dir_tab = '{
      // step before any segment: ignored
      '{STEP_REQ, 1'b0, NO_PIX},
      // single point: nothing drawn, following step ignored
      '{'{MODE_LOAD, 10'd5, 10'd5, 10'd5, 10'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      // horizontal, length one: end pixel with end color
      '{'{MODE_LOAD, 10'd0, 10'd0, 10'd1, 10'd0, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b1, '{10'd1, 10'd0, 8'd255, 8'd0, 8'd128, 1'b1}},
      '{STEP_REQ, 1'b0, NO_PIX},
      // vertical at the right edge, equal x kept in order
      '{'{MODE_LOAD, 10'd1023, 10'd0, 10'd1023, 10'd1, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b1, '{10'd1023, 10'd1, 8'd0, 8'd0, 8'd0, 1'b1}},
      // endpoints given right to left: swapped with their colors
      '{'{MODE_LOAD, 10'd3, 10'd0, 10'd1, 10'd2, 8'd200, 8'd7, 8'd99, 8'd1, 8'd250, 8'd33},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      // full-screen diagonal, abandoned after two pixels
      '{'{MODE_LOAD, 10'd1023, 10'd1023, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      // falling steep
      '{'{MODE_LOAD, 10'd0, 10'd4, 10'd1, 10'd0, 8'd0, 8'd100, 8'd255, 8'd255, 8'd101, 8'd0},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      // rising diagonal, the shallow case at its tie
      '{'{MODE_LOAD, 10'd0, 10'd0, 10'd2, 10'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8},
        1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      '{STEP_REQ, 1'b0, NO_PIX},
      // rising steep at the far column, one pixel then abandoned by random loads
      '{'{MODE_LOAD, 10'd1020, 10'd0, 10'd1023, 10'd1023, 8'd9, 8'd9, 8'd9, 8'd250, 8'd250, 8'd250},
        1'b0, NO_PIX}
    };
    dir_tab[NumDirected-1].req.ye = 10'd1023;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows
    for (int i = 0; i < NumDirected; i++) begin
      send(dir_tab[i].req, got, p);
      if (got) pix_expected.push_back(dir_tab[i].typed ? dir_tab[i].pix : p);
    end
    send(STEP_REQ, got, p);
    if (got) pix_expected.push_back(p);

    // Random segments: mostly complete walks, some abandoned, some stray steps
    items_sent = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 4) == 0) tx_calm = ~tx_calm;
      kind = $urandom_range(0, 9);
      q = rand_req(MODE_LOAD);
      if (kind != 0) begin
        bx = q.xs;
        by = q.ys;
        q.xe = nudge(bx, (kind == 1) ? 60 : 12);
        q.ye = nudge(by, (kind == 1) ? 60 : 12);
      end
      send(q, got, p);
      items_sent++;
      if (kind == 0 || kind == 2) steps = $urandom_range(0, (pen_len < 20) ? pen_len : 20);
      else steps = pen_len + $urandom_range(0, 2);
      for (int s = 0; s < steps; s++) begin
        send(rand_req(MODE_STEP), got, p);
        items_sent++;
        if (got) begin
          pix_expected.push_back(p);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pix_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
